// File: hw/rtl/s2l_pkg.sv
package s2l_pkg;

  // Widths of the datapath.
  localparam int LIN_W = 17;   // Q0.16 linear channel value, 0..65536
  localparam int NUM_W = 41;   // scaled matrix sum ahead of white-point division
  localparam int Q24_W = 25;   // Q0.24 normalized XYZ and companded values
  localparam int SUM_W = 33;   // matrix row sum

  typedef logic [LIN_W-1:0] lin_t;
  typedef logic [NUM_W-1:0] num_t;
  typedef logic [Q24_W-1:0] q24_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef lin_t lin_tbl_t [256];

  // White-point divisors and their rounding offsets.
  localparam int   DIV_X  = 95047;
  localparam int   DIV_Y  = 10000;
  localparam int   DIV_Z  = 108883;
  localparam num_t HALF_X = num_t'(47523);
  localparam num_t HALF_Y = num_t'(5000);
  localparam num_t HALF_Z = num_t'(54441);

  // Lab companding constants.
  localparam q24_t LAB_OFFSET = q24_t'(((64'd4 << 24) + 64'd14) / 64'd29);
  localparam q24_t LAB_KNEE   = q24_t'((64'd8856 << 24) / 64'd1000000);
  localparam logic [31:0] RECIP_1000 = 32'd2199023256;  // ceil(2^41 / 1000)

  // Output limits.
  localparam int L_MAX   = 25600;
  localparam int S16_MAX = 32767;
  localparam int S16_MIN = -32768;

  // Stage counts of each section.
  localparam int LAT_XYZ   = 3;
  localparam int LAT_DIV   = 3;
  localparam int LAT_F     = 2 * Q24_W + 3;
  localparam int LAT_LAB   = 2;
  localparam int LAT_TOTAL = LAT_XYZ + LAT_DIV + LAT_F + LAT_LAB;

  function automatic longint unsigned fifth_root_q30(longint unsigned target);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned sq;
    longint unsigned q4;
    longint unsigned q5;
    lo = 0;
    hi = (64'd1 << 30) + 64'd1;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      sq  = (mid * mid) >> 30;
      q4  = (sq * sq) >> 30;
      q5  = (q4 * mid) >> 30;
      if (q5 <= target) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  // sRGB decoding curve of one 8-bit code, in Q0.16.
  function automatic lin_t lin_value(int v);
    longint unsigned vv;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned r;
    longint unsigned p;
    vv = longint'(v) & 64'hFF;
    if (vv * 64'd100000 <= 64'd1031475) begin
      return lin_t'((vv * 64'd6553600 + 64'd164730) / 64'd329460);
    end
    t  = (((64'd1000 * vv + 64'd14025) << 30) + 64'd134512) / 64'd269025;
    t2 = (t * t) >> 30;
    r  = fifth_root_q30(t2);
    p  = (t2 * r) >> 30;
    return lin_t'((p + 64'd8192) >> 14);
  endfunction

  function automatic lin_tbl_t build_lin_tbl();
    lin_tbl_t tbl;
    for (int i = 0; i < 256; i++) begin
      tbl[i] = lin_value(i);
    end
    return tbl;
  endfunction

  localparam lin_tbl_t LIN_TBL = build_lin_tbl();

endpackage

// File: hw/rtl/s2l_xyz.sv
module s2l_xyz (
  input  logic          clk,
  input  logic          en,
  input  logic [7:0]    red,
  input  logic [7:0]    green,
  input  logic [7:0]    blue,
  output s2l_pkg::num_t num_x,
  output s2l_pkg::num_t num_y,
  output s2l_pkg::num_t num_z
);
  import s2l_pkg::*;

  lin_t r_r, g_r, b_r;
  sum_t sx_r, sy_r, sz_r;
  num_t nx_r, ny_r, nz_r;

  // Table lookup, matrix rows, then scaling with the rounding offset of each divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      r_r  <= LIN_TBL[red];
      g_r  <= LIN_TBL[green];
      b_r  <= LIN_TBL[blue];
      sx_r <= SUM_W'(r_r) * SUM_W'(41240) + SUM_W'(g_r) * SUM_W'(35760)
            + SUM_W'(b_r) * SUM_W'(18050);
      sy_r <= SUM_W'(r_r) * SUM_W'(2126) + SUM_W'(g_r) * SUM_W'(7152)
            + SUM_W'(b_r) * SUM_W'(722);
      sz_r <= SUM_W'(r_r) * SUM_W'(1930) + SUM_W'(g_r) * SUM_W'(11920)
            + SUM_W'(b_r) * SUM_W'(95050);
      nx_r <= {sx_r, 8'd0} + HALF_X;
      ny_r <= {sy_r, 8'd0} + HALF_Y;
      nz_r <= {sz_r, 8'd0} + HALF_Z;
    end
  end

  assign num_x = nx_r;
  assign num_y = ny_r;
  assign num_z = nz_r;

endmodule

// File: hw/rtl/s2l_cdiv.sv
module s2l_cdiv #(
  parameter int DIVISOR = s2l_pkg::DIV_Y,
  parameter int NUM_W   = s2l_pkg::NUM_W,
  parameter int QUO_W   = s2l_pkg::Q24_W
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  output logic [QUO_W-1:0] quo
);

  // Floor division by a constant through a reciprocal multiply. With the shift
  // at NUM_W + 17 the quotient is exact for any divisor from 4097 up to 2^17.
  localparam int HW = 23;
  localparam int NH = NUM_W - HW;
  localparam int SH = NUM_W + 17;
  localparam int MW = 2 * HW;
  localparam int PH = NH + HW;
  localparam int PL = 2 * HW;
  localparam int CW = PL + 1;
  localparam int PW = NUM_W + MW;
  localparam logic [MW-1:0] M =
    MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
  localparam logic [HW-1:0] M_HI = M[MW-1:HW];
  localparam logic [HW-1:0] M_LO = M[HW-1:0];

  logic [NH-1:0] n_hi;
  logic [HW-1:0] n_lo;
  logic [PH-1:0] hh_r, hl_r, hh2_r;
  logic [PL-1:0] lh_r, ll_r, ll2_r;
  logic [CW-1:0] cross_r;
  logic [PW-1:0] prod;
  logic [QUO_W-1:0] quo_r;

  assign n_hi = num[NUM_W-1:HW];
  assign n_lo = num[HW-1:0];

  // Partial products, then the cross terms, then the aligned sum.
  assign prod = (PW'(hh2_r) << MW) + (PW'(cross_r) << HW) + PW'(ll2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      hh_r    <= PH'(n_hi) * PH'(M_HI);
      hl_r    <= PH'(n_hi) * PH'(M_LO);
      lh_r    <= PL'(n_lo) * PL'(M_HI);
      ll_r    <= PL'(n_lo) * PL'(M_LO);
      cross_r <= CW'(hl_r) + CW'(lh_r);
      hh2_r   <= hh_r;
      ll2_r   <= ll_r;
      quo_r   <= prod[SH+QUO_W-1:SH];
    end
  end

  assign quo = quo_r;

endmodule

// File: hw/rtl/s2l_labf.sv
module s2l_labf (
  input  logic          clk,
  input  logic          en,
  input  s2l_pkg::q24_t c,
  output s2l_pkg::q24_t f
);
  import s2l_pkg::*;

  q24_t        c1_r, c2_r;
  logic [30:0] n_r;
  q24_t        lin_r;
  logic [62:0] lin_prod;
  q24_t        f_r;

  // Linear segment: 7.787*c rounded, with the divide by 1000 done by a reciprocal.
  // Only the low 18 bits of c matter, since the segment is used below the knee.
  assign lin_prod = {32'd0, n_r} * {31'd0, RECIP_1000};

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r  <= c;
      n_r   <= 31'(c[17:0]) * 31'(7787) + 31'(500);
      c2_r  <= c1_r;
      lin_r <= q24_t'(lin_prod[62:41]) + LAB_OFFSET;
    end
  end

  // Cube root by bitwise search: each bit spends one stage on the square and one on the cube.
  for (genvar j = 0; j < Q24_W; j++) begin : g_root
    localparam q24_t BIT = q24_t'(1) << (Q24_W - 1 - j);
    q24_t        lo_in, c_in, lin_in, mid;
    logic [49:0] sq_full;
    logic [50:0] cu_full;
    q24_t        mid_r;
    logic [25:0] sq_r;
    q24_t        ca_r, lina_r, rt_r, cb_r, linb_r;

    if (j == 0) begin : g_first
      assign lo_in  = '0;
      assign c_in   = c2_r;
      assign lin_in = lin_r;
    end else begin : g_next
      assign lo_in  = g_root[j-1].rt_r;
      assign c_in   = g_root[j-1].cb_r;
      assign lin_in = g_root[j-1].linb_r;
    end

    assign mid     = lo_in | BIT;
    assign sq_full = {25'd0, mid} * {25'd0, mid};
    assign cu_full = {25'd0, sq_r} * {26'd0, mid_r};

    always_ff @(posedge clk) begin
      if (en) begin
        mid_r  <= mid;
        sq_r   <= sq_full[49:24];
        ca_r   <= c_in;
        lina_r <= lin_in;
        rt_r   <= (cu_full[50:24] <= 27'(ca_r)) ? mid_r : (mid_r & ~BIT);
        cb_r   <= ca_r;
        linb_r <= lina_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r <= (g_root[Q24_W-1].cb_r > LAB_KNEE) ? g_root[Q24_W-1].rt_r
                                                : g_root[Q24_W-1].linb_r;
    end
  end

  assign f = f_r;

endmodule

// File: hw/rtl/s2l_lab.sv
module s2l_lab (
  input  logic               clk,
  input  logic               en,
  input  s2l_pkg::q24_t      fx,
  input  s2l_pkg::q24_t      fy,
  input  s2l_pkg::q24_t      fz,
  output logic [14:0]        lightness,
  output logic signed [15:0] green_red,
  output logic signed [15:0] blue_yellow
);
  import s2l_pkg::*;

  logic signed [35:0] fxs, fys, fzs;
  logic signed [35:0] lq_r, aq_r, bq_r;
  logic signed [35:0] lsum, asum, bsum;
  logic signed [19:0] lrnd, arnd, brnd;
  logic [14:0]        l_nxt;
  logic signed [15:0] a_nxt, b_nxt;
  logic [14:0]        l_r;
  logic signed [15:0] a_r, b_r;

  assign fxs = signed'(36'(fx));
  assign fys = signed'(36'(fy));
  assign fzs = signed'(36'(fz));

  // Rounding half up to Q8.8 is an add of one half and an arithmetic shift.
  always_comb begin
    lsum = lq_r + 36'sd32768;
    asum = aq_r + 36'sd32768;
    bsum = bq_r + 36'sd32768;
    lrnd = lsum[35:16];
    arnd = asum[35:16];
    brnd = bsum[35:16];

    if (lrnd < 20'sd0) l_nxt = '0;
    else if (lrnd > 20'(L_MAX)) l_nxt = 15'(L_MAX);
    else l_nxt = lrnd[14:0];

    if (arnd > 20'(S16_MAX)) a_nxt = 16'(S16_MAX);
    else if (arnd < 20'(S16_MIN)) a_nxt = 16'(S16_MIN);
    else a_nxt = arnd[15:0];

    if (brnd > 20'(S16_MAX)) b_nxt = 16'(S16_MAX);
    else if (brnd < 20'(S16_MIN)) b_nxt = 16'(S16_MIN);
    else b_nxt = brnd[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lq_r <= fys * 36'sd116 - 36'sd268435456;
      aq_r <= (fxs - fys) * 36'sd500;
      bq_r <= (fys - fzs) * 36'sd200;
      l_r  <= l_nxt;
      a_r  <= a_nxt;
      b_r  <= b_nxt;
    end
  end

  assign lightness   = l_r;
  assign green_red   = a_r;
  assign blue_yellow = b_r;

endmodule

// File: hw/rtl/srgb_to_cielab.sv
// Channel   Direction  Handshake            Word
// in_       input      in_valid / in_stall   red, green, blue (8-bit sRGB codes)
// out_      output     out_valid / out_stall lightness (Q8.8), green_red, blue_yellow
//
// The pipeline takes one word per clock unless a stalled output holds it. A word
// accepted at in_ reaches the out_ ports and is taken when out_stall is low; most of
// the length is the 50-stage cube-root search, which spends two stages on each result
// bit, and the white-point dividers add three stages of reciprocal multiply.
// Reset (rst_n low at a clock edge) clears only the valid bits of the pipeline.
// A stall on the output freezes every stage at once, so in_stall is high exactly
// while a finished word waits on a stalled output; no word is lost or repeated.
module srgb_to_cielab (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [14:0]        out_lightness,
  output logic signed [15:0] out_green_red,
  output logic signed [15:0] out_blue_yellow
);
  import s2l_pkg::*;

  logic                 en;
  logic [LAT_TOTAL-1:0] vld_r;
  num_t                 num_x, num_y, num_z;
  q24_t                 nx, ny, nz;
  q24_t                 fx, fy, fz;

  // The whole pipeline advances together unless the output register holds a
  // word that the far side is not taking.
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT_TOTAL-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[LAT_TOTAL-1];

  // Linearize each channel and form the three scaled matrix rows.
  s2l_xyz u_xyz (
    .clk   (clk),
    .en    (en),
    .red   (in_red),
    .green (in_green),
    .blue  (in_blue),
    .num_x (num_x),
    .num_y (num_y),
    .num_z (num_z)
  );

  // Normalize by the white point with rounding.
  s2l_cdiv #(.DIVISOR(DIV_X), .NUM_W(NUM_W), .QUO_W(Q24_W)) u_div_x (
    .clk (clk), .en (en), .num (num_x), .quo (nx)
  );
  s2l_cdiv #(.DIVISOR(DIV_Y), .NUM_W(NUM_W), .QUO_W(Q24_W)) u_div_y (
    .clk (clk), .en (en), .num (num_y), .quo (ny)
  );
  s2l_cdiv #(.DIVISOR(DIV_Z), .NUM_W(NUM_W), .QUO_W(Q24_W)) u_div_z (
    .clk (clk), .en (en), .num (num_z), .quo (nz)
  );

  // Lab companding of each normalized component.
  s2l_labf u_f_x (.clk (clk), .en (en), .c (nx), .f (fx));
  s2l_labf u_f_y (.clk (clk), .en (en), .c (ny), .f (fy));
  s2l_labf u_f_z (.clk (clk), .en (en), .c (nz), .f (fz));

  // L*, a* and b* with rounding and saturation; its last stage is the output register.
  s2l_lab u_lab (
    .clk         (clk),
    .en          (en),
    .fx          (fx),
    .fy          (fy),
    .fz          (fz),
    .lightness   (out_lightness),
    .green_red   (out_green_red),
    .blue_yellow (out_blue_yellow)
  );

  // A delivered lightness never exceeds 100.0.
  a_l_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lightness <= 15'(L_MAX)))
    else $error("lightness above range");

  // A stalled output freezes the valid bits of every stage.
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  // An accepted word enters the first stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted word not captured");

endmodule

// File: bench/srgb_to_cielab_checker.sv
module srgb_to_cielab_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [14:0]        out_lightness,
  input  logic signed [15:0] out_green_red,
  input  logic signed [15:0] out_blue_yellow,
  output int                 mismatches,
  output int                 pending
);

  typedef struct packed {
    logic [14:0]        lightness;
    logic signed [15:0] green_red;
    logic signed [15:0] blue_yellow;
  } lab_word_t;

  lab_word_t lab_fifo[$];
  logic [16:0] decode_curve [256];

  function automatic longint unsigned root5_q30(longint unsigned goal);
    longint unsigned lo, hi, m, s2, s4, s5;
    lo = 0;
    hi = (64'd1 << 30) + 1;
    while (hi - lo > 1) begin
      m  = (lo + hi) >> 1;
      s2 = (m * m) >> 30;
      s4 = (s2 * s2) >> 30;
      s5 = (s4 * m) >> 30;
      if (s5 <= goal) lo = m;
      else hi = m;
    end
    return lo;
  endfunction

  function automatic longint unsigned root3_q24(longint unsigned goal);
    longint unsigned lo, hi, m, s2, s3;
    lo = 0;
    hi = 64'd1 << 25;
    while (hi - lo > 1) begin
      m  = (lo + hi) >> 1;
      s2 = (m * m) >> 24;
      s3 = (s2 * m) >> 24;
      if (s3 <= goal) lo = m;
      else hi = m;
    end
    return lo;
  endfunction

  // Gamma decoding of one code to Q0.16: linear toe, then the 2.4 power law
  // done as t^2 multiplied by the fifth root of t^2.
  function automatic logic [16:0] decode_code(longint unsigned code);
    longint unsigned t, t2, r, p;
    if (code * 100000 <= 1031475) return 17'((code * 6553600 + 164730) / 329460);
    t  = (((1000 * code + 14025) << 30) + 134512) / 269025;
    t2 = (t * t) >> 30;
    r  = root5_q30(t2);
    p  = (t2 * r) >> 30;
    return 17'((p + 8192) >> 14);
  endfunction

  function automatic longint compand(longint unsigned c);
    if (c * 1000000 > (64'd8856 << 24)) return longint'(root3_q24(c));
    return longint'((7787 * c + 500) / 1000 + (((64'd4 << 24) + 14) / 29));
  endfunction

  function automatic longint to_q8_8(longint x, longint lo, longint hi);
    longint y;
    y = (x + 32768) >>> 16;
    return y < lo ? lo : (y > hi ? hi : y);
  endfunction

  function automatic lab_word_t convert_pixel(logic [7:0] rc, logic [7:0] gc, logic [7:0] bc);
    longint unsigned r, g, b, x, y, z;
    longint fx, fy, fz;
    lab_word_t w;
    r = decode_curve[rc];
    g = decode_curve[gc];
    b = decode_curve[bc];
    x = ((41240 * r + 35760 * g + 18050 * b) * 256 + 47523) / 95047;
    y = ((2126 * r + 7152 * g + 722 * b) * 256 + 5000) / 10000;
    z = ((1930 * r + 11920 * g + 95050 * b) * 256 + 54441) / 108883;
    fx = compand(x);
    fy = compand(y);
    fz = compand(z);
    w.lightness   = 15'(to_q8_8(116 * fy - (longint'(16) << 24), 0, 25600));
    w.green_red   = 16'(to_q8_8(500 * (fx - fy), -32768, 32767));
    w.blue_yellow = 16'(to_q8_8(200 * (fy - fz), -32768, 32767));
    return w;
  endfunction

  initial begin
    for (int i = 0; i < 256; i++) decode_curve[i] = decode_code(i);
  end

  assign pending = lab_fifo.size();

  always @(posedge clk) begin
    lab_word_t want;
    if (rst_n && in_valid && !in_stall)
      lab_fifo.push_back(convert_pixel(in_red, in_green, in_blue));
    if (rst_n && out_valid && !out_stall) begin
      if (lab_fifo.size() == 0) begin
        $error("unexpected word: L=%0d a=%0d b=%0d", out_lightness, out_green_red,
               out_blue_yellow);
        mismatches++;
      end else begin
        want = lab_fifo.pop_front();
        if (out_lightness !== want.lightness) begin
          $error("lightness: expected %0d, got %0d", want.lightness, out_lightness);
          mismatches++;
        end
        if (out_green_red !== want.green_red) begin
          $error("green_red: expected %0d, got %0d", want.green_red, out_green_red);
          mismatches++;
        end
        if (out_blue_yellow !== want.blue_yellow) begin
          $error("blue_yellow: expected %0d, got %0d", want.blue_yellow, out_blue_yellow);
          mismatches++;
        end
      end
    end
  end

endmodule

// File: bench/srgb_to_cielab_test.sv
module srgb_to_cielab_test;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_red = '0;
  logic [7:0]         in_green = '0;
  logic [7:0]         in_blue = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [14:0]        out_lightness;
  logic signed [15:0] out_green_red;
  logic signed [15:0] out_blue_yellow;
  int                 mismatches;
  int                 pending;
  int                 cycle_count = 0;
  // Upper bound on idle cycles per word; zero gives stretches at full rate.
  int                 send_gap_max = 8;
  int                 recv_gap_max = 8;

  localparam int RANDOM_WORDS = 1700;
  localparam int CYCLE_LIMIT  = 400000;

  // The period is 8 time units: 4 high, 4 low.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  srgb_to_cielab uut (.*);

  srgb_to_cielab_checker watcher (.*);

  // A hung handshake or a lost word ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sends one pixel word. The valid is only lowered when a gap follows, so
  // back-to-back words never see two assignments to in_valid in one step.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    bit held;
    gap = $urandom_range(send_gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    // The stall is read mid-cycle, where it is settled for the coming edge.
    do begin
      @(negedge clk);
      held = in_stall;
      @(posedge clk);
    end while (held);
  endtask

  // Output side: before each word it holds the stall for a random number of
  // cycles, then releases it until a word is taken.
  initial begin
    int n;
    bit got;
    @(posedge clk iff rst_n);
    forever begin
      n = $urandom_range(recv_gap_max, 0);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        got = out_valid;
        @(posedge clk);
      end while (!got);
    end
  end

  initial begin
    int tone;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: black and white, the primaries and secondaries, the
    // edge of the linear toe of the sRGB curve (code 10 against 11), dark
    // values near the companding knee, and full-scale chroma that can push
    // a* and b* toward saturation.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd10, 8'd10, 8'd10);
    send_pixel(8'd11, 8'd11, 8'd11);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd24, 8'd24, 8'd24);
    send_pixel(8'd25, 8'd25, 8'd25);
    send_pixel(8'd26, 8'd26, 8'd26);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd0, 8'd1, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd170);
    send_pixel(8'd85, 8'd170, 8'd85);

    // Random words in phases of 200; some phases drop the idling on one or
    // both sides so the pipeline also runs full and drains at full rate.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 200 == 0) begin
        send_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 8;
        recv_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 8;
      end
      case ($urandom_range(9, 0))
        0: begin
          // Near-gray dark pixels land around the knee of the Lab curve.
          tone = $urandom_range(40, 0);
          send_pixel(8'(tone), 8'(tone + $urandom_range(2, 0)), 8'(tone));
        end
        1: send_pixel(8'($urandom_range(255, 0) & 8'hF0 | 8'hF), 8'($urandom_range(15, 0)),
                      8'($urandom_range(255, 0)));
        default: send_pixel(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                            8'($urandom_range(255, 0)));
      endcase
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
